FILE: rtl/positional_insert_queue_pair_defines.svh
// ----------------------------------------------------------------------------
// positional_insert_queue_pair_defines
// Assertion macros shared by the queue pair RTL.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_INSERT_QUEUE_PAIR_DEFINES_SVH
`define POSITIONAL_INSERT_QUEUE_PAIR_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define PIQP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("piqp assertion failed");
// next-cycle implication
`define PIQP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("piqp assertion failed");
`else
`define PIQP_ASSERT_NOW(label, clk, rst, ante, cons)
`define PIQP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/piqp_pkg.sv
// ----------------------------------------------------------------------------
// piqp_pkg
// Field widths, operation and status codes, controller command type.
// ----------------------------------------------------------------------------
package piqp_pkg;

  localparam int MODE_W    = 2;
  localparam int ID_W      = 32;
  localparam int TAG_W     = 32;
  localparam int POS_W     = 8;
  localparam int STATUS_W  = 2;
  localparam int CNT_OUT_W = 8;

  // stream payload widths, padded to whole bytes
  localparam int IN_RAW_W   = MODE_W + ID_W + TAG_W + POS_W;
  localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W  = STATUS_W + 2 * CNT_OUT_W + ID_W + TAG_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MOVE   = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_WAIT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_WAIT_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_SRV_DROP   = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch the incoming item
    logic exec;     // run the operation and load the result register
  } piqp_cmd_t;

endpackage

FILE: rtl/piqp_ram.sv
// ----------------------------------------------------------------------------
// piqp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module piqp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/piqp_ctrl.sv
// ----------------------------------------------------------------------------
// piqp_ctrl
// Handshake controller: capture an item, execute it, hold the result.
// ----------------------------------------------------------------------------
`include "positional_insert_queue_pair_defines.svh"

module piqp_ctrl
  import piqp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  logic      m_tready,
  output piqp_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free    = !m_tvalid || m_tready;
  assign s_tready    = (state == ST_IDLE);
  assign cmd.capture = (state == ST_IDLE) && s_tvalid;
  assign cmd.exec    = (state == ST_EXEC) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if (cmd.exec) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `PIQP_ASSERT_NEXT(a_capture_to_exec, clk, rst, s_tvalid && s_tready, state == ST_EXEC)
  `PIQP_ASSERT_NEXT(a_exec_gives_result, clk, rst, cmd.exec, m_tvalid && state == ST_IDLE)
  `PIQP_ASSERT_NEXT(a_stall_holds_exec, clk, rst, state == ST_EXEC && !out_free, state == ST_EXEC)

endmodule

FILE: rtl/piqp_dp.sv
// ----------------------------------------------------------------------------
// piqp_dp
// Datapath: item register, waiting shift-register queue, served RAM,
// fill counters and result register.
// ----------------------------------------------------------------------------
`include "positional_insert_queue_pair_defines.svh"

module piqp_dp
  import piqp_pkg::*;
#(
  parameter int DEPTH    = 128,
  parameter int ID_BITS  = 32,
  parameter int TAG_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  piqp_cmd_t             cmd,
  input  logic [IN_DATA_W-1:0]  in_data,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int REC_W = ID_BITS + TAG_BITS;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // captured item
  logic [MODE_W-1:0] mode;
  logic [ID_W-1:0]   rid;
  logic [TAG_W-1:0]  rtag;
  logic [POS_W-1:0]  pos;

  // waiting queue cells, head in entry 0
  logic [REC_W-1:0] wq_entry [DEPTH];
  logic [CNT_W-1:0] wfill, wfill_next;
  logic [CNT_W-1:0] sfill, sfill_next;

  // result register
  logic [STATUS_W-1:0]  res_status;
  logic [CNT_OUT_W-1:0] res_wcnt;
  logic [CNT_OUT_W-1:0] res_scnt;
  logic [ID_W-1:0]      res_mid;
  logic [TAG_W-1:0]     res_mtag;

  logic [REC_W-1:0]    wr_rec;
  logic [CNT_W-1:0]    slot;
  logic                w_full, w_empty, s_full, is_add, pos_hit;
  logic                do_add, do_move, do_store;
  logic [STATUS_W-1:0] status_next;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode <= in_data[MODE_W-1:0];
      rid  <= in_data[MODE_W +: ID_W];
      rtag <= in_data[MODE_W+ID_W +: TAG_W];
      pos  <= in_data[MODE_W+ID_W+TAG_W +: POS_W];
    end
  end

  always_comb begin
    wr_rec   = {rtag[TAG_BITS-1:0], rid[ID_BITS-1:0]};
    is_add   = (mode == MODE_APPEND) || (mode == MODE_INSERT);
    w_full   = (wfill == FULL_CNT);
    w_empty  = (wfill == '0);
    s_full   = (sfill == FULL_CNT);
    pos_hit  = (mode == MODE_INSERT) && (pos != '0) && (CMP_W'(pos) <= CMP_W'(wfill));
    slot     = pos_hit ? CNT_W'(pos - POS_W'(1)) : wfill;
    do_add   = cmd.exec && is_add && !w_full;
    do_move  = cmd.exec && (mode == MODE_MOVE) && !w_empty;
    do_store = do_move && !s_full;

    wfill_next = wfill;
    sfill_next = sfill;
    if (do_add) begin
      wfill_next = wfill + CNT_W'(1);
    end else if (do_move) begin
      wfill_next = wfill - CNT_W'(1);
    end
    if (do_store) begin
      sfill_next = sfill + CNT_W'(1);
    end

    status_next = STATUS_OK;
    if (is_add && w_full) begin
      status_next = STATUS_WAIT_FULL;
    end else if (mode == MODE_MOVE) begin
      if (w_empty) begin
        status_next = STATUS_WAIT_EMPTY;
      end else if (s_full) begin
        status_next = STATUS_SRV_DROP;
      end
    end
  end

  // each entry: load, take from the entry ahead (insert shift) or behind (dequeue)
  for (genvar i = 0; i < DEPTH; i++) begin : g_entry
    always_ff @(posedge clk) begin
      if (do_add) begin
        if (CNT_W'(i) == slot) begin
          wq_entry[i] <= wr_rec;
        end else if (CNT_W'(i) > slot && CNT_W'(i) <= wfill) begin
          wq_entry[i] <= wq_entry[(i > 0) ? i - 1 : 0];
        end
      end else if (do_move) begin
        wq_entry[i] <= wq_entry[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wfill <= '0;
      sfill <= '0;
    end else begin
      wfill <= wfill_next;
      sfill <= sfill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status <= status_next;
      res_wcnt   <= CNT_OUT_W'(wfill_next);
      res_scnt   <= CNT_OUT_W'(sfill_next);
      res_mid    <= do_move ? ID_W'(wq_entry[0][ID_BITS-1:0]) : '0;
      res_mtag   <= do_move ? TAG_W'(wq_entry[0][REC_W-1:ID_BITS]) : '0;
    end
  end

  // served queue storage, appended at the tail
  piqp_ram #(
    .WIDTH (REC_W),
    .DEPTH (DEPTH)
  ) u_served (
    .clk     (clk),
    .wr_en   (do_store),
    .wr_addr (sfill[IDX_W-1:0]),
    .wr_data (wq_entry[0]),
    .rd_addr ('0),
    .rd_data ()
  );

  assign out_data = {(OUT_DATA_W - OUT_RAW_W)'(0), res_mtag, res_mid,
                     res_scnt, res_wcnt, res_status};

  `PIQP_ASSERT_NOW(a_wfill_range, clk, rst, 1'b1, wfill <= FULL_CNT && sfill <= FULL_CNT)
  `PIQP_ASSERT_NEXT(a_sfill_monotonic, clk, rst, 1'b1, sfill >= $past(sfill))
  `PIQP_ASSERT_NEXT(a_move_shrinks, clk, rst, do_move, wfill == $past(wfill) - CNT_W'(1))
  `PIQP_ASSERT_NOW(a_add_move_excl, clk, rst, do_add, !do_move && !do_store)

endmodule

FILE: rtl/positional_insert_queue_pair.sv
// ----------------------------------------------------------------------------
// positional_insert_queue_pair
// Waiting / served record queue pair with positional insert into waiting.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Group             Payload
//  -------   ---   ---------------   ------------------------------------------
//  input     in    s_tvalid/tready   mode, record_id, record_tag, position
//  result    out   m_tvalid/tready   status, waiting_count, served_count,
//                                    moved_id, moved_tag
//
//  Each item is captured in the idle state, then the execute state runs the
//  operation on the waiting shift-register cells and served RAM and loads
//  the result register. The execute state waits while the previous result
//  is still not taken; a new item is captured as soon as the execute state
//  is done, even with a result pending. rst is synchronous and clears both
//  counts and the controller; record storage needs no clearing pass.
//
module positional_insert_queue_pair
  import piqp_pkg::*;
#(
  parameter int DEPTH    = 128,
  parameter int ID_BITS  = 32,
  parameter int TAG_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  // input transfer
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [1:0] mode, [33:2] record_id, [65:34] record_tag, [73:66] position, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // result transfer
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [1:0] status, [9:2] waiting_count, [17:10] served_count,
  // [49:18] moved_id, [81:50] moved_tag, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata
);

  piqp_cmd_t cmd;

  // handshake sequencing
  piqp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // queues, counters and result register
  piqp_dp #(
    .DEPTH    (DEPTH),
    .ID_BITS  (ID_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (s_tdata),
    .out_data (m_tdata)
  );

endmodule

FILE: dv/positional_insert_queue_pair_tb.sv
// ----------------------------------------------------------------------------
// positional_insert_queue_pair_tb
// Self-checking bench for the waiting / served record queue pair. A mirror of
// both queues predicts the status, counts and moved record of every transfer.
// Stimulus runs directed corner cases, a long random mix, a fill to capacity
// with the result side held off, and a drain through served-queue overflow.
// ----------------------------------------------------------------------------
module positional_insert_queue_pair_tb;
  import piqp_pkg::*;

  localparam int QDEPTH      = 128;
  localparam int STALL_LIMIT = 2000;   // cycles with no transfer on either side
  localparam int HOLD_CYCLES = 300;    // long result-side hold-off
  localparam int RANDOM_OPS  = 1650;
  localparam int MAX_REPORTS = 10;

  // mode 3 has no package name; the block treats it as a no-op
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // field order matches s_tdata, first member in the top bits
  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [TAG_W-1:0]  tag;
    logic [ID_W-1:0]   id;
    logic [MODE_W-1:0] mode;
  } queue_op_t;

  // field order matches m_tdata
  typedef struct packed {
    logic [TAG_W-1:0]     moved_tag;
    logic [ID_W-1:0]      moved_id;
    logic [CNT_OUT_W-1:0] served_count;
    logic [CNT_OUT_W-1:0] waiting_count;
    logic [STATUS_W-1:0]  status;
  } queue_report_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [ID_W-1:0]  id;
  } record_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // mirror of the block state, updated at each accepted input transfer
  record_t       waiting_mirror[$];
  record_t       served_mirror[$];
  queue_report_t reports_due[$];

  int mismatches   = 0;
  int ops_sent     = 0;
  int reports_seen = 0;
  int hits_full    = 0;
  int hits_empty   = 0;
  int hits_drop    = 0;
  int mid_inserts  = 0;

  int send_zero_run = 0;
  int recv_zero_run = 0;
  int hold_cycles   = 0;   // set by a test, consumed by the receiver

  always #5 clk = ~clk;

  positional_insert_queue_pair #(
    .DEPTH   (QDEPTH),
    .ID_BITS (ID_W),
    .TAG_BITS(TAG_W)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  // --------------------------------------------------------------------------
  // Prediction: apply one operation to the mirror and queue its report.
  // --------------------------------------------------------------------------
  function automatic void predict_queue_op(input queue_op_t op);
    queue_report_t rpt;
    record_t       rec;
    int            slot;
    rpt = '0;
    rec.id  = op.id;
    rec.tag = op.tag;
    if (op.mode == MODE_APPEND || op.mode == MODE_INSERT) begin
      if (waiting_mirror.size() >= QDEPTH) begin
        rpt.status = STATUS_WAIT_FULL;
        hits_full++;
      end else begin
        slot = waiting_mirror.size();
        // insert only lands inside the queue for 1..count; else append
        if (op.mode == MODE_INSERT && op.pos != 0 && op.pos <= waiting_mirror.size()) begin
          slot = op.pos - 1;
          mid_inserts++;
        end
        waiting_mirror.insert(slot, rec);
        rpt.status = STATUS_OK;
      end
    end else if (op.mode == MODE_MOVE) begin
      if (waiting_mirror.size() == 0) begin
        rpt.status = STATUS_WAIT_EMPTY;
        hits_empty++;
      end else begin
        rec = waiting_mirror.pop_front();
        rpt.moved_id  = rec.id;
        rpt.moved_tag = rec.tag;
        // head still leaves waiting even when served has no room
        if (served_mirror.size() >= QDEPTH) begin
          rpt.status = STATUS_SRV_DROP;
          hits_drop++;
        end else begin
          served_mirror.push_back(rec);
          rpt.status = STATUS_OK;
        end
      end
    end else begin
      rpt.status = STATUS_OK;
    end
    rpt.waiting_count = CNT_OUT_W'(waiting_mirror.size());
    rpt.served_count  = CNT_OUT_W'(served_mirror.size());
    reports_due.push_back(rpt);
  endfunction

  // per-item idle draw: a random gap, with occasional runs of no idling
  function automatic int draw_wait(inout int zero_run);
    if (zero_run > 0) begin
      zero_run--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      zero_run = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  // insert position: mostly inside the queue, some 0, past count, or any value
  function automatic logic [POS_W-1:0] pick_position(input int count);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50 && count > 0) return POS_W'($urandom_range(1, count));
    if (roll < 65) return '0;
    if (roll < 80 && count < 255) return POS_W'($urandom_range(count + 1, 255));
    return POS_W'($urandom_range(0, 255));
  endfunction

  function automatic queue_op_t make_op(input logic [MODE_W-1:0] mode,
                                        input logic [ID_W-1:0] id,
                                        input logic [TAG_W-1:0] tag,
                                        input logic [POS_W-1:0] pos);
    queue_op_t op;
    op.mode = mode;
    op.id   = id;
    op.tag  = tag;
    op.pos  = pos;
    return op;
  endfunction

  // --------------------------------------------------------------------------
  // Input side: drive at the falling edge, wait for the transfer, predict.
  // valid stays high across back-to-back items (gap 0).
  // --------------------------------------------------------------------------
  task automatic send_op(input queue_op_t op, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_DATA_W'(op);
    do @(posedge clk); while (!s_tready);
    predict_queue_op(op);
    ops_sent++;
  endtask

  task automatic idle_input();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result side: random hold-off per transfer, plus the long hold on request.
  // --------------------------------------------------------------------------
  initial begin
    int w;
    @(negedge clk);
    forever begin
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      w = draw_wait(recv_zero_run);
      if (w > 0) begin
        m_tready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Checker: each result transfer against the oldest prediction.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] %s mismatch: expected 0x%0h, got 0x%0h", $realtime, name, want, got);
    end
  endtask

  initial begin
    queue_report_t want;
    queue_report_t got;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got = m_tdata[OUT_RAW_W-1:0];
        reports_seen++;
        if (reports_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] result transfer with nothing pending: 0x%0h", $realtime, got);
        end else begin
          want = reports_due.pop_front();
          check_field("status",        want.status,        got.status);
          check_field("waiting_count", want.waiting_count, got.waiting_count);
          check_field("served_count",  want.served_count,  got.served_count);
          check_field("moved_id",      want.moved_id,      got.moved_id);
          check_field("moved_tag",     want.moved_tag,     got.moved_tag);
        end
      end
    end
  end

  // Watchdog: too long with no transfer on either side means a hang.
  initial begin
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        stalled = 0;
      else
        stalled++;
    end
    $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // empty-queue move, spare mode, field extremes, every kind of position
  task automatic test_directed();
    send_op(make_op(MODE_MOVE,   '0, '0, '0), draw_wait(send_zero_run));
    send_op(make_op(MODE_SPARE,  '0, '0, '0), draw_wait(send_zero_run));
    send_op(make_op(MODE_APPEND, '0, '0, '0), draw_wait(send_zero_run));
    send_op(make_op(MODE_APPEND, '1, '1, '1), draw_wait(send_zero_run));
    // position 0 appends
    send_op(make_op(MODE_INSERT, 32'h0000_0a01, 32'h0000_0b01, 8'd0), 0);
    // position 1 goes to the head
    send_op(make_op(MODE_INSERT, 32'h0000_0a02, 32'h0000_0b02, 8'd1), 0);
    // far past the count appends
    send_op(make_op(MODE_INSERT, 32'h0000_0a03, 32'h0000_0b03, 8'd255), 0);
    // position equal to count: lands before the last entry
    send_op(make_op(MODE_INSERT, 32'h0000_0a04, 32'h0000_0b04, 8'd5), 0);
    // count + 1 appends
    send_op(make_op(MODE_INSERT, 32'h0000_0a05, 32'h0000_0b05, 8'd7), 0);
    send_op(make_op(MODE_INSERT, 32'h5555_5555, 32'haaaa_aaaa, 8'd3), draw_wait(send_zero_run));
    send_op(make_op(MODE_INSERT, 32'haaaa_aaaa, 32'h5555_5555, 8'd128), draw_wait(send_zero_run));
    // spare mode with every field set changes nothing
    send_op(make_op(MODE_SPARE, '1, '1, '1), draw_wait(send_zero_run));
    // drain everything, then one more move on the empty queue
    repeat (10) send_op(make_op(MODE_MOVE, $urandom, $urandom, $urandom), draw_wait(send_zero_run));
  endtask

  // random mix; drift between filling and draining phases so the count wanders
  task automatic test_random_mix(input int n_ops);
    queue_op_t op;
    int        fill_lean;
    int        roll;
    fill_lean = 1;
    for (int i = 0; i < n_ops; i++) begin
      if (i % 200 == 0) fill_lean = $urandom_range(0, 1);
      roll    = $urandom_range(0, 99);
      op.id   = $urandom;
      op.tag  = $urandom;
      op.pos  = pick_position(waiting_mirror.size());
      if (roll < 3)
        op.mode = MODE_SPARE;
      else if (roll < (fill_lean ? 70 : 42))
        op.mode = (roll % 3 != 0) ? MODE_INSERT : MODE_APPEND;
      else
        op.mode = MODE_MOVE;
      send_op(op, draw_wait(send_zero_run));
    end
  endtask

  // results held off while items go in back to back: the block must stall its
  // input; then keep adding until waiting is full and a few more bounce off
  task automatic test_fill_under_hold();
    hold_cycles = HOLD_CYCLES;
    while (waiting_mirror.size() < QDEPTH)
      send_op(make_op($urandom_range(0, 1) ? MODE_INSERT : MODE_APPEND, $urandom, $urandom,
                      pick_position(waiting_mirror.size())), 0);
    send_op(make_op(MODE_APPEND, $urandom, $urandom, $urandom), 0);
    send_op(make_op(MODE_INSERT, $urandom, $urandom, 8'd1), draw_wait(send_zero_run));
    send_op(make_op(MODE_INSERT, $urandom, $urandom, 8'd0), draw_wait(send_zero_run));
    send_op(make_op(MODE_SPARE, $urandom, $urandom, $urandom), draw_wait(send_zero_run));
  endtask

  // sender goes quiet until every pending result has come out
  task automatic test_sender_pause();
    idle_input();
    while (reports_due.size() != 0) @(posedge clk);
  endtask

  // move until waiting is empty; served overflows along the way if not already
  task automatic test_drain_waiting();
    while (waiting_mirror.size() > 0)
      send_op(make_op(MODE_MOVE, $urandom, $urandom, $urandom), draw_wait(send_zero_run));
    repeat (2) send_op(make_op(MODE_MOVE, $urandom, $urandom, $urandom), draw_wait(send_zero_run));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_mix(RANDOM_OPS);
    test_fill_under_hold();
    test_sender_pause();
    test_drain_waiting();

    idle_input();
    while (reports_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d input transfers and checked %0d results, %0d mismatches.",
             ops_sent, reports_seen, mismatches);
    $display("Waiting full %0d times, moves on empty %0d, served drops %0d, mid inserts %0d.",
             hits_full, hits_empty, hits_drop, mid_inserts);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
